// ===== sv/audio_point_perspective_projector_top_defines.svh =====
// Assertion macros for the perspective projector checker.
// Used only by apj_checker; expects a clk and rst in scope.
`ifndef AUDIO_POINT_PERSPECTIVE_PROJECTOR_TOP_DEFINES_SVH
`define AUDIO_POINT_PERSPECTIVE_PROJECTOR_TOP_DEFINES_SVH

// same-cycle implication, off while in reset
`define APJ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while in reset
`define APJ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also runs through reset
`define APJ_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/apj_pkg.sv =====
// Shared constants, stage map, register codes and word types of the projector.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package apj_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 16;
  localparam int AGE_BITS       = 20;
  localparam int CHAN_BITS      = 6;
  localparam int COEF_BITS      = 32;
  localparam int ROW_BITS       = 48;
  localparam int PIX_BITS       = 13;
  localparam int WT_BITS        = 9;
  localparam int SIZE_BITS      = 14;
  localparam int FRAME_CAP      = 8192;

  // product and sum widths of one row
  localparam int PS_BITS  = COEF_BITS + SAMPLE_BITS;
  localparam int PC_BITS  = COEF_BITS + CHAN_BITS + 1;
  localparam int PA_BITS  = COEF_BITS + AGE_BITS + 1;
  localparam int SUM_BITS = PA_BITS + 2;

  // viewport division widths
  localparam int VW_BITS  = ROW_BITS + 1;
  localparam int D_BITS   = ROW_BITS + 1;
  localparam int SZM_BITS = SIZE_BITS + 1;
  localparam int NUM_BITS = VW_BITS + SZM_BITS;
  localparam int REM_BITS = D_BITS + PIX_BITS;

  // weight division widths
  localparam int WQ_BITS  = 8;
  localparam int WD_BITS  = COEF_FRAC_BITS + 9;
  localparam int WR_BITS  = WD_BITS + WQ_BITS;

  // pipeline stage map
  localparam int ST_PROD  = 0;
  localparam int ST_ROW   = 1;
  localparam int ST_PREP  = 2;
  localparam int ST_MUL   = 3;
  localparam int ST_MAG   = 4;
  localparam int ST_DIV0  = 5;
  localparam int ST_DIVN  = ST_DIV0 + PIX_BITS - 1;
  localparam int ST_WDIVN = ST_DIV0 + WQ_BITS - 1;
  localparam int ST_OUT   = ST_DIVN + 1;
  localparam int NSTAGE   = ST_OUT + 1;

  // configuration port
  localparam int CFG_ADDR_BITS = 6;
  localparam int CFG_DATA_BITS = 64;
  localparam int REG_IDX_BITS  = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_COEF_X_SC   = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_COEF_X_AO   = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_COEF_Y_SC   = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_COEF_Y_AO   = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_COEF_W_SC   = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_COEF_W_AO   = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_FRAME_WIDTH = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 3'd7;

  localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 14'd1280;
  localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 14'd720;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic [CHAN_BITS-1:0]          channel_index;
    logic [AGE_BITS-1:0]           age_index;
  } in_t;

  typedef struct packed {
    logic [PIX_BITS-1:0]  pixel_x;
    logic [PIX_BITS-1:0]  pixel_y;
    logic [WT_BITS-1:0]   depth_weight;
    logic                 visible;
    logic [CHAN_BITS-1:0] channel_out;
  } out_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] quo;
    logic                neg;
    logic                big;
  } axis_res_t;

endpackage

// ===== sv/apj_row.sv =====
// One projection row: three products, then floor shift, sum and saturation.
// Depends on apj_pkg; pipeline enables come from the top level.
`timescale 1ns / 1ps

module apj_row (
  input  logic                                      clk,
  input  logic [apj_pkg::NSTAGE-1:0]                en,
  input  logic [2*apj_pkg::COEF_BITS-1:0]           coef_sc,
  input  logic [2*apj_pkg::COEF_BITS-1:0]           coef_ao,
  input  logic signed [apj_pkg::SAMPLE_BITS-1:0]    sample,
  input  logic [apj_pkg::CHAN_BITS-1:0]             chan,
  input  logic [apj_pkg::AGE_BITS-1:0]              age,
  output logic signed [apj_pkg::ROW_BITS-1:0]       row
);

  localparam int CB = apj_pkg::COEF_BITS;
  localparam int SB = apj_pkg::SUM_BITS;
  localparam logic signed [SB-1:0] SAT_HI = (SB'(1) <<< (apj_pkg::ROW_BITS - 1)) - SB'(1);
  localparam logic signed [SB-1:0] SAT_LO = -SAT_HI - SB'(1);

  logic signed [CB-1:0] ks, kc, ka, ko;
  logic signed [apj_pkg::PS_BITS-1:0] ps;
  logic signed [apj_pkg::PC_BITS-1:0] pc;
  logic signed [apj_pkg::PA_BITS-1:0] pa;
  logic signed [SB-1:0] sum;

  assign ks = coef_sc[CB-1:0];
  assign kc = coef_sc[2*CB-1:CB];
  assign ka = coef_ao[CB-1:0];
  assign ko = coef_ao[2*CB-1:CB];

  always_ff @(posedge clk) begin
    if (en[apj_pkg::ST_PROD]) begin
      ps <= ks * sample;
      pc <= kc * $signed({1'b0, chan});
      pa <= ka * $signed({1'b0, age});
    end
  end

  // floor shift keeps the coefficient fraction
  assign sum = SB'(ps >>> (apj_pkg::SAMPLE_BITS - 1)) + SB'(pc) + SB'(pa) + SB'(ko);

  always_ff @(posedge clk) begin
    if (en[apj_pkg::ST_ROW]) begin
      if (sum > SAT_HI) begin
        row <= apj_pkg::ROW_BITS'(SAT_HI);
      end else if (sum < SAT_LO) begin
        row <= apj_pkg::ROW_BITS'(SAT_LO);
      end else begin
        row <= apj_pkg::ROW_BITS'(sum);
      end
    end
  end

endmodule

// ===== sv/apj_axis.sv =====
// Viewport mapping of one axis: (size-1)*(v+w) divided by 2w, one quotient bit a stage.
// Depends on apj_pkg; pipeline enables come from the top level.
`timescale 1ns / 1ps

module apj_axis (
  input  logic                                clk,
  input  logic [apj_pkg::NSTAGE-1:0]          en,
  input  logic signed [apj_pkg::ROW_BITS-1:0] v,
  input  logic signed [apj_pkg::ROW_BITS-1:0] w,
  input  logic [apj_pkg::SIZE_BITS-1:0]       size_reg,
  output apj_pkg::axis_res_t                  res
);

  localparam int PB = apj_pkg::PIX_BITS;
  localparam int RB = apj_pkg::REM_BITS;
  localparam int NB = apj_pkg::NUM_BITS;

  logic [apj_pkg::SIZE_BITS-1:0]       sz;
  logic signed [apj_pkg::SZM_BITS-1:0] szm1;
  logic signed [apj_pkg::VW_BITS-1:0]  wext, wabs;

  logic signed [apj_pkg::VW_BITS-1:0]  vw2;
  logic [apj_pkg::D_BITS-1:0]          d2, d3;
  logic                                wneg2, wneg3;
  logic signed [NB-1:0]                num3;
  logic [NB-1:0]                       nmag;

  logic [RB-1:0]                rem_p [0:PB];
  logic [PB-1:0]                q_p   [0:PB];
  logic [apj_pkg::D_BITS-1:0]   d_p   [0:PB];
  logic                         neg_p [0:PB];
  logic                         big_p [0:PB];

  assign sz   = (size_reg > apj_pkg::SIZE_BITS'(apj_pkg::FRAME_CAP)) ?
                apj_pkg::SIZE_BITS'(apj_pkg::FRAME_CAP) : size_reg;
  assign szm1 = $signed({1'b0, sz}) - apj_pkg::SZM_BITS'(1);
  assign wext = apj_pkg::VW_BITS'(w);
  assign wabs = w[apj_pkg::ROW_BITS-1] ? -wext : wext;

  always_ff @(posedge clk) begin
    if (en[apj_pkg::ST_PREP]) begin
      vw2   <= apj_pkg::VW_BITS'(v) + wext;
      d2    <= {wabs[apj_pkg::ROW_BITS-1:0], 1'b0};
      wneg2 <= w[apj_pkg::ROW_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[apj_pkg::ST_MUL]) begin
      num3  <= NB'(szm1) * NB'(vw2);
      d3    <= d2;
      wneg3 <= wneg2;
    end
  end

  assign nmag = num3[NB-1] ? NB'(-num3) : NB'(num3);

  always_ff @(posedge clk) begin
    if (en[apj_pkg::ST_MAG]) begin
      rem_p[0] <= nmag[RB-1:0];
      q_p[0]   <= '0;
      d_p[0]   <= d3;
      neg_p[0] <= num3[NB-1] ^ wneg3;
      // quotient of 2^PIX_BITS or more is always off the picture
      big_p[0] <= nmag >= (NB'(d3) << PB);
    end
  end

  for (genvar j = 0; j < PB; j++) begin : g_step
    logic [RB-1:0] trial;
    logic          ge;
    assign trial = RB'(d_p[j]) << (PB - 1 - j);
    assign ge    = rem_p[j] >= trial;
    always_ff @(posedge clk) begin
      if (en[apj_pkg::ST_DIV0 + j]) begin
        rem_p[j+1] <= ge ? rem_p[j] - trial : rem_p[j];
        q_p[j+1]   <= {q_p[j][PB-2:0], ge};
        d_p[j+1]   <= d_p[j];
        neg_p[j+1] <= neg_p[j];
        big_p[j+1] <= big_p[j];
      end
    end
  end

  assign res = '{quo: q_p[PB], neg: neg_p[PB], big: big_p[PB]};

endmodule

// ===== sv/apj_weight.sv =====
// Depth weight clip(1/w, 0, 1) in Q1.8: flags, then one quotient bit a stage.
// Depends on apj_pkg; pipeline enables come from the top level.
`timescale 1ns / 1ps

module apj_weight (
  input  logic                                clk,
  input  logic [apj_pkg::NSTAGE-1:0]          en,
  input  logic signed [apj_pkg::ROW_BITS-1:0] w,
  output logic [apj_pkg::WT_BITS-1:0]         weight
);

  localparam int NW = apj_pkg::ST_DIVN - apj_pkg::ST_PREP + 1;
  localparam int RB = apj_pkg::WR_BITS;
  localparam int QB = apj_pkg::WQ_BITS;
  localparam logic signed [apj_pkg::ROW_BITS-1:0] W_ONE =
    apj_pkg::ROW_BITS'(1) <<< apj_pkg::COEF_FRAC_BITS;
  localparam logic signed [apj_pkg::ROW_BITS-1:0] W_MAX =
    apj_pkg::ROW_BITS'(1) <<< (apj_pkg::COEF_FRAC_BITS + 8);

  logic [RB-1:0]                 rem_p [0:NW-1];
  logic [QB-1:0]                 q_p   [0:NW-1];
  logic [apj_pkg::WD_BITS-1:0]   d_p   [0:NW-1];
  logic                          pos_p [0:NW-1];
  logic                          sat_p [0:NW-1];
  logic                          zro_p [0:NW-1];

  always_ff @(posedge clk) begin
    if (en[apj_pkg::ST_PREP]) begin
      rem_p[0] <= RB'(1) << (apj_pkg::COEF_FRAC_BITS + 8);
      q_p[0]   <= '0;
      d_p[0]   <= w[apj_pkg::WD_BITS-1:0];
      pos_p[0] <= (w > 0);
      sat_p[0] <= (w <= W_ONE);
      zro_p[0] <= (w > W_MAX);
    end
  end

  for (genvar k = 1; k < NW; k++) begin : g_stage
    localparam int ST = apj_pkg::ST_PREP + k;
    if (ST >= apj_pkg::ST_DIV0 && ST <= apj_pkg::ST_WDIVN) begin : g_div
      logic [RB-1:0] trial;
      logic          ge;
      assign trial = RB'(d_p[k-1]) << (apj_pkg::ST_WDIVN - ST);
      assign ge    = rem_p[k-1] >= trial;
      always_ff @(posedge clk) begin
        if (en[ST]) begin
          rem_p[k] <= ge ? rem_p[k-1] - trial : rem_p[k-1];
          q_p[k]   <= {q_p[k-1][QB-2:0], ge};
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en[ST]) begin
          rem_p[k] <= rem_p[k-1];
          q_p[k]   <= q_p[k-1];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en[ST]) begin
        d_p[k]   <= d_p[k-1];
        pos_p[k] <= pos_p[k-1];
        sat_p[k] <= sat_p[k-1];
        zro_p[k] <= zro_p[k-1];
      end
    end
  end

  always_comb begin
    if (!pos_p[NW-1] || zro_p[NW-1]) begin
      weight = '0;
    end else if (sat_p[NW-1]) begin
      weight = apj_pkg::WT_BITS'(256);
    end else begin
      weight = {1'b0, q_p[NW-1]};
    end
  end

endmodule

// ===== sv/audio_point_perspective_projector_top.sv =====
// Perspective projector top: config registers, stage control, output word.
// Depends on apj_pkg, apj_row, apj_axis and apj_weight.
//
//   channel | handshake          | word
//   --------+--------------------+------------------------------------
//   in      | in_valid/in_ready  | in_data (sample, channel, age)
//   out     | out_valid/out_ready| out_data (pixel, weight, visible)
//   cfg     | APB psel/penable   | 64-bit coefficients and frame size
//
// One word per cycle while out_ready stays high at the output port.
// Latency is set by the 13 quotient-bit stages of the viewport divide.
// Each stage advances when the next one is empty or advancing, so a
// stalled output fills bubbles upstream before in_ready drops.
// Reset (rst, synchronous) empties the pipe and loads register defaults.
`timescale 1ns / 1ps

module audio_point_perspective_projector_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  apj_pkg::in_t                         in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output apj_pkg::out_t                        out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [apj_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [apj_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [apj_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                 pready
);

  localparam int NS = apj_pkg::NSTAGE;

  logic [apj_pkg::CFG_DATA_BITS-1:0] coef_x_sc, coef_x_ao, coef_y_sc, coef_y_ao;
  logic [apj_pkg::CFG_DATA_BITS-1:0] coef_w_sc, coef_w_ao;
  logic [apj_pkg::SIZE_BITS-1:0]     frame_width, frame_height;
  logic [apj_pkg::REG_IDX_BITS-1:0]  reg_idx;
  logic                              cfg_wr;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  logic signed [apj_pkg::ROW_BITS-1:0] row_x, row_y, row_w;
  apj_pkg::axis_res_t                  res_x, res_y;
  logic [apj_pkg::WT_BITS-1:0]         weight;

  logic [apj_pkg::CHAN_BITS-1:0] chan_p [0:apj_pkg::ST_DIVN];
  logic                          wz_p   [apj_pkg::ST_PREP:apj_pkg::ST_DIVN];
  logic                          in_x, in_y, vis;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[apj_pkg::CFG_ADDR_BITS-1:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x_sc    <= '0;
      coef_x_ao    <= '0;
      coef_y_sc    <= '0;
      coef_y_ao    <= '0;
      coef_w_sc    <= '0;
      coef_w_ao    <= '0;
      frame_width  <= apj_pkg::WIDTH_RESET;
      frame_height <= apj_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        apj_pkg::REG_COEF_X_SC:    coef_x_sc    <= pwdata;
        apj_pkg::REG_COEF_X_AO:    coef_x_ao    <= pwdata;
        apj_pkg::REG_COEF_Y_SC:    coef_y_sc    <= pwdata;
        apj_pkg::REG_COEF_Y_AO:    coef_y_ao    <= pwdata;
        apj_pkg::REG_COEF_W_SC:    coef_w_sc    <= pwdata;
        apj_pkg::REG_COEF_W_AO:    coef_w_ao    <= pwdata;
        apj_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[apj_pkg::SIZE_BITS-1:0];
        apj_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[apj_pkg::SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      apj_pkg::REG_COEF_X_SC:    prdata = coef_x_sc;
      apj_pkg::REG_COEF_X_AO:    prdata = coef_x_ao;
      apj_pkg::REG_COEF_Y_SC:    prdata = coef_y_sc;
      apj_pkg::REG_COEF_Y_AO:    prdata = coef_y_ao;
      apj_pkg::REG_COEF_W_SC:    prdata = coef_w_sc;
      apj_pkg::REG_COEF_W_AO:    prdata = coef_w_ao;
      apj_pkg::REG_FRAME_WIDTH:  prdata = apj_pkg::CFG_DATA_BITS'(frame_width);
      apj_pkg::REG_FRAME_HEIGHT: prdata = apj_pkg::CFG_DATA_BITS'(frame_height);
      default:                   prdata = '0;
    endcase
  end

  // stage control: a stage loads when it is empty or its successor moves
  assign en[NS-1] = !vld[NS-1] || out_ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (vld & ~en) | ({vld[NS-2:0], in_valid} & en);
    end
  end

  apj_row u_row_x (
    .clk(clk), .en(en), .coef_sc(coef_x_sc), .coef_ao(coef_x_ao),
    .sample(in_data.sample_value), .chan(in_data.channel_index),
    .age(in_data.age_index), .row(row_x)
  );

  apj_row u_row_y (
    .clk(clk), .en(en), .coef_sc(coef_y_sc), .coef_ao(coef_y_ao),
    .sample(in_data.sample_value), .chan(in_data.channel_index),
    .age(in_data.age_index), .row(row_y)
  );

  apj_row u_row_w (
    .clk(clk), .en(en), .coef_sc(coef_w_sc), .coef_ao(coef_w_ao),
    .sample(in_data.sample_value), .chan(in_data.channel_index),
    .age(in_data.age_index), .row(row_w)
  );

  apj_axis u_axis_x (
    .clk(clk), .en(en), .v(row_x), .w(row_w), .size_reg(frame_width), .res(res_x)
  );

  apj_axis u_axis_y (
    .clk(clk), .en(en), .v(row_y), .w(row_w), .size_reg(frame_height), .res(res_y)
  );

  apj_weight u_weight (
    .clk(clk), .en(en), .w(row_w), .weight(weight)
  );

  // sideband: channel and zero-w flag ride along with the word
  always_ff @(posedge clk) begin
    if (en[0]) begin
      chan_p[0] <= in_data.channel_index;
    end
  end

  for (genvar k = 1; k <= apj_pkg::ST_DIVN; k++) begin : g_chan
    always_ff @(posedge clk) begin
      if (en[k]) begin
        chan_p[k] <= chan_p[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[apj_pkg::ST_PREP]) begin
      wz_p[apj_pkg::ST_PREP] <= (row_w == '0);
    end
  end

  for (genvar k = apj_pkg::ST_PREP + 1; k <= apj_pkg::ST_DIVN; k++) begin : g_wz
    always_ff @(posedge clk) begin
      if (en[k]) begin
        wz_p[k] <= wz_p[k-1];
      end
    end
  end

  function automatic logic inside_view(apj_pkg::axis_res_t r,
                                       logic [apj_pkg::SIZE_BITS-1:0] size_reg);
    logic [apj_pkg::SIZE_BITS-1:0] sz;
    sz = (size_reg > apj_pkg::SIZE_BITS'(apj_pkg::FRAME_CAP)) ?
         apj_pkg::SIZE_BITS'(apj_pkg::FRAME_CAP) : size_reg;
    return (sz != '0) && !r.big &&
           ((r.quo == '0) || (!r.neg && (apj_pkg::SIZE_BITS'(r.quo) < sz)));
  endfunction

  assign in_x = inside_view(res_x, frame_width);
  assign in_y = inside_view(res_y, frame_height);
  assign vis  = in_x && in_y && !wz_p[apj_pkg::ST_DIVN];

  always_ff @(posedge clk) begin
    if (en[apj_pkg::ST_OUT]) begin
      out_data.pixel_x      <= vis ? res_x.quo : '0;
      out_data.pixel_y      <= vis ? res_y.quo : '0;
      out_data.depth_weight <= wz_p[apj_pkg::ST_DIVN] ? '0 : weight;
      out_data.visible      <= vis;
      out_data.channel_out  <= chan_p[apj_pkg::ST_DIVN];
    end
  end

endmodule

// ===== sv/apj_checker.sv =====
// Port-level checks of the projector top, attached by bind.
// Depends on apj_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "audio_point_perspective_projector_top_defines.svh"

module apj_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  apj_pkg::in_t                      in_data,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  apj_pkg::out_t                     out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [apj_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [apj_pkg::CFG_DATA_BITS-1:0] pwdata,
  input  logic [apj_pkg::CFG_DATA_BITS-1:0] prdata,
  input  logic                              pready
);

  `APJ_ASSERT_RST(a_rst_empty, rst, !out_valid, "output word valid right after reset")

  `APJ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled output word changed")

  `APJ_ASSERT_IMP(a_hidden_zero, out_valid && !out_data.visible, (out_data.pixel_x == '0) && (out_data.pixel_y == '0), "hidden word carries a pixel")

  `APJ_ASSERT_IMP(a_weight_cap, out_valid, out_data.depth_weight <= apj_pkg::WT_BITS'(256), "depth weight above one")

endmodule

bind audio_point_perspective_projector_top apj_checker u_apj_checker (.*);
